// ===== src/fcba_pkg.sv =====
// ============================================================================
// FAT chain block allocator package
// Shared field widths, link codes, command codes and the microprogram that
// sequences the link table datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

  // Field widths of the ports.
  localparam int KIND_W   = 3;
  localparam int START_W  = 10;
  localparam int BOFF_W   = 20;
  localparam int ST_W     = 2;
  localparam int BLKOUT_W = 10;
  localparam int OFFS_W   = 10;
  localparam int CFG_W    = 10;
  localparam int LINK_W   = 16;

  // Link codes stored in the table.
  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

  // First allocatable block after reset.
  localparam logic [CFG_W-1:0] RESET_FIRST = 10'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [ST_W-1:0] ST_END     = 2'd2;

  // Command codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_EXTEND = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_SEEK   = 3'd4
  } kind_t;

  // Control word fields.
  typedef enum logic [1:0] {
    RAM_IDLE,
    RAM_RD,
    RAM_WR
  } ram_op_t;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_SCAN,
    ADDR_HIT,
    ADDR_WID
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_FMT,
    WD_END,
    WD_FREE,
    WD_HIT
  } wdata_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CUR_CLR,
    ACT_CUR_INC,
    ACT_SCAN_START,
    ACT_SCAN_ADV,
    ACT_SET_LNK,
    ACT_SET_BLK,
    ACT_SET_ST1,
    ACT_SET_ST2,
    ACT_FOLLOW,
    ACT_STEP,
    ACT_SET_SEEK
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_INIT,
    COND_OUT_BUSY,
    COND_NOT_ACCEPT,
    COND_START_OOR,
    COND_NOT_END,
    COND_SCAN_NONE,
    COND_SCAN_GO,
    COND_HIT_NONE,
    COND_NOT_EXT,
    COND_WALK_STOP,
    COND_REM_LT,
    COND_LNK_OK
  } cond_t;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    ram_op_t    ram;
    addr_sel_t  addr;
    wdata_sel_t wd;
    act_t       act;
    cond_t      cond;
    logic       disp;
    logic       emit;
    pc_t        target;
  } uword_t;

  // Microprogram step addresses.
  localparam pc_t P_FMT0     = 5'd0;
  localparam pc_t P_FMT      = 5'd1;
  localparam pc_t P_FMT_END  = 5'd2;
  localparam pc_t P_EMIT     = 5'd3;
  localparam pc_t P_IDLE     = 5'd4;
  localparam pc_t P_DISP     = 5'd5;
  localparam pc_t P_EXT      = 5'd6;
  localparam pc_t P_EXT_RD   = 5'd7;
  localparam pc_t P_EXT_CHK  = 5'd8;
  localparam pc_t P_SCAN     = 5'd9;
  localparam pc_t P_SCAN_RD  = 5'd10;
  localparam pc_t P_SCAN_CHK = 5'd11;
  localparam pc_t P_SCAN_HIT = 5'd12;
  localparam pc_t P_TAKE     = 5'd13;
  localparam pc_t P_LINK     = 5'd14;
  localparam pc_t P_FAIL1    = 5'd15;
  localparam pc_t P_FREE     = 5'd16;
  localparam pc_t P_FREE_WR  = 5'd17;
  localparam pc_t P_SEEK     = 5'd18;
  localparam pc_t P_SEEK_LP  = 5'd19;
  localparam pc_t P_SEEK_CHK = 5'd20;
  localparam pc_t P_FAIL2    = 5'd21;
  localparam pc_t P_SEEK_OK  = 5'd22;

  // Packs one control word.
  function automatic uword_t uw(input ram_op_t ram, input addr_sel_t addr,
                                input wdata_sel_t wd, input act_t act,
                                input cond_t cond, input logic disp,
                                input logic emit, input pc_t target);
    uword_t w;
    w.ram    = ram;
    w.addr   = addr;
    w.wd     = wd;
    w.act    = act;
    w.cond   = cond;
    w.disp   = disp;
    w.emit   = emit;
    w.target = target;
    return w;
  endfunction

  // Control store. A step jumps to its target (a dispatch step to the entry step
  // of the command) when its condition holds and otherwise falls through to the next step.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      // Format: sweep the whole table, then report or return to idle.
      P_FMT0:     w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_CUR_CLR, COND_NEVER,
                         1'b0, 1'b0, P_FMT);
      P_FMT:      w = uw(RAM_WR, ADDR_CUR, WD_FMT, ACT_CUR_INC, COND_NOT_LAST,
                         1'b0, 1'b0, P_FMT);
      P_FMT_END:  w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_INIT,
                         1'b0, 1'b0, P_IDLE);
      // Result hand-off and command intake.
      P_EMIT:     w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_OUT_BUSY,
                         1'b0, 1'b1, P_EMIT);
      P_IDLE:     w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_NOT_ACCEPT,
                         1'b0, 1'b0, P_IDLE);
      P_DISP:     w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_ALWAYS,
                         1'b1, 1'b0, P_EMIT);
      // Extend: reject an out-of-range start, return the stored link or fall into the free-block scan.
      P_EXT:      w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_START_OOR,
                         1'b0, 1'b0, P_FAIL1);
      P_EXT_RD:   w = uw(RAM_RD, ADDR_CUR, WD_FMT, ACT_NONE, COND_NEVER,
                         1'b0, 1'b0, P_EMIT);
      P_EXT_CHK:  w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_SET_LNK, COND_NOT_END,
                         1'b0, 1'b0, P_EMIT);
      // Free-block scan, one entry per cycle with reads running ahead.
      P_SCAN:     w = uw(RAM_IDLE, ADDR_SCAN, WD_FMT, ACT_SCAN_START, COND_SCAN_NONE,
                         1'b0, 1'b0, P_FAIL1);
      P_SCAN_RD:  w = uw(RAM_RD, ADDR_SCAN, WD_FMT, ACT_SCAN_ADV, COND_NEVER,
                         1'b0, 1'b0, P_EMIT);
      P_SCAN_CHK: w = uw(RAM_RD, ADDR_SCAN, WD_FMT, ACT_SCAN_ADV, COND_SCAN_GO,
                         1'b0, 1'b0, P_SCAN_CHK);
      P_SCAN_HIT: w = uw(RAM_IDLE, ADDR_HIT, WD_END, ACT_NONE, COND_HIT_NONE,
                         1'b0, 1'b0, P_FAIL1);
      P_TAKE:     w = uw(RAM_WR, ADDR_HIT, WD_END, ACT_SET_BLK, COND_NOT_EXT,
                         1'b0, 1'b0, P_EMIT);
      P_LINK:     w = uw(RAM_WR, ADDR_CUR, WD_HIT, ACT_NONE, COND_ALWAYS,
                         1'b0, 1'b0, P_EMIT);
      P_FAIL1:    w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_SET_ST1, COND_ALWAYS,
                         1'b0, 1'b0, P_EMIT);
      // Free: read a link, clear the entry, follow the old link.
      P_FREE:     w = uw(RAM_RD, ADDR_WID, WD_FREE, ACT_NONE, COND_WALK_STOP,
                         1'b0, 1'b0, P_EMIT);
      P_FREE_WR:  w = uw(RAM_WR, ADDR_WID, WD_FREE, ACT_FOLLOW, COND_ALWAYS,
                         1'b0, 1'b0, P_FREE);
      // Seek: follow one link per block size of remaining offset.
      P_SEEK:     w = uw(RAM_IDLE, ADDR_WID, WD_FMT, ACT_NONE, COND_START_OOR,
                         1'b0, 1'b0, P_FAIL2);
      P_SEEK_LP:  w = uw(RAM_RD, ADDR_WID, WD_FMT, ACT_NONE, COND_REM_LT,
                         1'b0, 1'b0, P_SEEK_OK);
      P_SEEK_CHK: w = uw(RAM_IDLE, ADDR_WID, WD_FMT, ACT_STEP, COND_LNK_OK,
                         1'b0, 1'b0, P_SEEK_LP);
      P_FAIL2:    w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_SET_ST2, COND_ALWAYS,
                         1'b0, 1'b0, P_EMIT);
      P_SEEK_OK:  w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_SET_SEEK, COND_ALWAYS,
                         1'b0, 1'b0, P_EMIT);
      default:    w = uw(RAM_IDLE, ADDR_CUR, WD_FMT, ACT_NONE, COND_ALWAYS,
                         1'b0, 1'b0, P_IDLE);
    endcase
    return w;
  endfunction

  // Dispatch table: entry step of each command.
  function automatic pc_t dispatch(input logic [KIND_W-1:0] kind);
    pc_t p;
    case (kind)
      KIND_FORMAT: p = P_FMT0;
      KIND_ALLOC:  p = P_SCAN;
      KIND_EXTEND: p = P_EXT;
      KIND_FREE:   p = P_FREE;
      KIND_SEEK:   p = P_SEEK;
      default:     p = P_EMIT;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== src/fat_chain_block_allocator_unit.sv =====
// ============================================================================
// FAT chain block allocator
// Link table manager with format, allocate, extend, free and seek commands.
// ============================================================================
// The block holds a table of BLOCKS 16-bit links in one RAM, where 0 marks a
// free block and all ones the end of a chain, and runs one command per input
// transaction with exactly one result transaction. A microprogram steps a
// small datapath through the table over one shared RAM address, so the run
// time depends on the command: format writes every entry; allocate scans one
// entry per cycle from first_alloc_block up to the first free entry; extend
// returns the stored link, or allocates and links a new block when the block
// ends a chain; free reads and clears each chain block; seek reads one link
// per block followed. After reset a formatting pass writes the whole table,
// and no command is taken during it. Configuration writes take effect on the
// next command and do not reformat the table.

`timescale 1ns / 1ps
`default_nettype none

module fat_chain_block_allocator_unit
  import fcba_pkg::*;
#(
  parameter int BLOCKS     = 1024,
  parameter int BLOCK_SIZE = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration.
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  // Command channel.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [START_W-1:0]  start_block,
  input  wire logic [BOFF_W-1:0]   byte_offset,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ST_W-1:0]          status,
  output logic [BLKOUT_W-1:0]      block_out,
  output logic [OFFS_W-1:0]        offset_in_block
);

  localparam int IW = $clog2(BLOCKS);
  localparam int CW = IW + 1;
  localparam logic [LINK_W:0] BLK_LIM   = (LINK_W + 1)'(BLOCKS);
  localparam logic [IW-1:0]   LAST_IDX  = IW'(BLOCKS - 1);
  localparam logic [CW-1:0]   CNT_MAX   = CW'(BLOCKS);
  localparam logic [BOFF_W:0] BS_WIDE   = (BOFF_W + 1)'(BLOCK_SIZE);

  // Control state.
  pc_t                pc;
  pc_t                pc_next;
  logic               init_pass;
  logic [CFG_W-1:0]   first_alloc_block;
  logic [CFG_W-1:0]   first_lim;
  logic [IW-1:0]      cur;

  // Datapath registers.
  logic [KIND_W-1:0]  kind_r;
  logic [LINK_W-1:0]  wid;
  logic [BOFF_W-1:0]  rem;
  logic [CW-1:0]      cnt;
  logic [IW-1:0]      scan;
  logic [IW-1:0]      chk;
  logic [IW-1:0]      hit;
  logic               hit_free;
  logic [ST_W-1:0]    res_status;
  logic [BLKOUT_W-1:0] res_block;
  logic [OFFS_W-1:0]  res_offs;

  // Sequencer signals.
  uword_t             cw;
  logic               cond_true;
  logic               in_accept;
  logic               emit_fire;

  // Link table port.
  logic               ram_we;
  logic               ram_re;
  logic [IW-1:0]      ram_addr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;

  // Current control word.
  assign cw        = ucode(pc);
  assign in_ready  = (pc == P_IDLE);
  assign in_accept = in_valid && in_ready;
  assign emit_fire = cw.emit && !(out_valid && !out_ready);

  // Branch condition of the current step.
  always_comb begin
    case (cw.cond)
      COND_NEVER:      cond_true = 1'b0;
      COND_ALWAYS:     cond_true = 1'b1;
      COND_NOT_LAST:   cond_true = (cur != LAST_IDX);
      COND_INIT:       cond_true = init_pass;
      COND_OUT_BUSY:   cond_true = out_valid && !out_ready;
      COND_NOT_ACCEPT: cond_true = !in_valid;
      COND_START_OOR:  cond_true = ({1'b0, wid} >= BLK_LIM);
      COND_NOT_END:    cond_true = (ram_rdata != LINK_END);
      COND_SCAN_NONE:  cond_true = ((LINK_W + 1)'(first_lim) >= BLK_LIM);
      COND_SCAN_GO:    cond_true = !(ram_rdata == LINK_FREE || chk == LAST_IDX);
      COND_HIT_NONE:   cond_true = !hit_free;
      COND_NOT_EXT:    cond_true = (kind_r != KIND_EXTEND);
      COND_WALK_STOP:  cond_true = ({1'b0, wid} >= BLK_LIM) || (cnt == CNT_MAX);
      COND_REM_LT:     cond_true = ({1'b0, rem} < BS_WIDE);
      COND_LNK_OK:     cond_true = (ram_rdata != LINK_END) &&
                                   ({1'b0, ram_rdata} < BLK_LIM);
      default:         cond_true = 1'b0;
    endcase
  end

  // Next step: jump target, dispatch by command, or fall through.
  always_comb begin
    if (cond_true) begin
      pc_next = cw.disp ? dispatch(kind_r) : cw.target;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  // Table address and write data selection.
  always_comb begin
    case (cw.addr)
      ADDR_CUR:  ram_addr = cur;
      ADDR_SCAN: ram_addr = scan;
      ADDR_HIT:  ram_addr = hit;
      ADDR_WID:  ram_addr = wid[IW-1:0];
      default:   ram_addr = cur;
    endcase
    case (cw.wd)
      WD_FMT:  ram_wdata = ((LINK_W + 1)'(cur) < (LINK_W + 1)'(first_lim)) ?
                           LINK_END : LINK_FREE;
      WD_END:  ram_wdata = LINK_END;
      WD_FREE: ram_wdata = LINK_FREE;
      WD_HIT:  ram_wdata = LINK_W'(hit);
      default: ram_wdata = LINK_FREE;
    endcase
  end

  assign ram_we = (cw.ram == RAM_WR);
  assign ram_re = (cw.ram == RAM_RD);

  // Link table.
  fcba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (BLOCKS)
  ) u_link_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Control registers. Reset starts the formatting pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc                <= P_FMT;
      init_pass         <= 1'b1;
      first_alloc_block <= RESET_FIRST;
      first_lim         <= RESET_FIRST;
      cur               <= '0;
      out_valid         <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_wr_en) begin
        first_alloc_block <= cfg_wr_data;
      end
      if (in_accept) begin
        init_pass <= 1'b0;
        first_lim <= first_alloc_block;
        cur       <= IW'(start_block);
      end else if (cw.act == ACT_CUR_CLR) begin
        cur <= '0;
      end else if (cw.act == ACT_CUR_INC) begin
        cur <= cur + 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r     <= kind;
      wid        <= LINK_W'(start_block);
      rem        <= byte_offset;
      cnt        <= '0;
      res_status <= ST_OK;
      res_block  <= '0;
      res_offs   <= '0;
    end else begin
      case (cw.act)
        ACT_SCAN_START: scan <= IW'(first_lim);
        ACT_SCAN_ADV: begin
          scan     <= scan + 1'b1;
          chk      <= scan;
          hit      <= chk;
          hit_free <= (ram_rdata == LINK_FREE);
        end
        ACT_SET_LNK: res_block <= BLKOUT_W'(ram_rdata);
        ACT_SET_BLK: res_block <= BLKOUT_W'(hit);
        ACT_SET_ST1: begin
          res_status <= ST_NO_FREE;
          res_block  <= '0;
        end
        ACT_SET_ST2: begin
          res_status <= ST_END;
          res_block  <= '0;
        end
        ACT_FOLLOW: begin
          wid <= ram_rdata;
          cnt <= cnt + 1'b1;
        end
        ACT_STEP: begin
          wid <= ram_rdata;
          rem <= rem - BS_WIDE[BOFF_W-1:0];
        end
        ACT_SET_SEEK: begin
          res_block <= BLKOUT_W'(wid);
          res_offs  <= rem[OFFS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      status          <= res_status;
      block_out       <= res_block;
      offset_in_block <= res_offs;
    end
  end

  // An accepted command is always dispatched on the next cycle.
  assert property (@(posedge clk) disable iff (rst) in_accept |=> pc == P_DISP)
    else $error("accepted command was not dispatched");

  // The table is never written while waiting for a command.
  assert property (@(posedge clk) disable iff (rst) pc == P_IDLE |-> !ram_we)
    else $error("table write while idle");

  // A failing result never carries a block index.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (status == ST_OK || block_out == '0))
    else $error("block index reported with an error status");

  // A successful seek always ends on a block inside the table.
  assert property (@(posedge clk) disable iff (rst)
                   pc == P_SEEK_OK |-> {1'b0, wid} < BLK_LIM)
    else $error("seek ended outside the table");

endmodule

`default_nettype wire

// ===== src/fcba_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fcba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
